FILE: hdl/assert_macros.svh
// Assertion macros shared by the console RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
// Types and constants of the text console writer.
// No dependencies; used by the console modules.
package tcw_pkg;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] code;
  } cell_t;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam cell_t BLANK_CELL = '{color: 8'h00, code: 8'h20};
  localparam int CELL_BITS = $bits(cell_t);

endpackage

FILE: hdl/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the console cell store.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/tcw_addr_unit.sv
// Shared address adder: adds two cell indexes modulo the screen size.
// No dependencies; used by the console sequencer for every store address.
module tcw_addr_unit #(
  parameter int CELLS = 2000,
  localparam int AW = $clog2(CELLS)
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  output logic [AW-1:0] sum
);

  logic [AW:0] raw;
  logic [AW:0] wrapped;

  assign raw     = {1'b0, a} + {1'b0, b};
  assign wrapped = raw - (AW+1)'(CELLS);
  assign sum     = (raw >= (AW+1)'(CELLS)) ? wrapped[AW-1:0] : raw[AW-1:0];

endmodule

FILE: hdl/text_console_writer_top.sv
// Text console writer: cell store, cursor, circular top row and sequencer.
// Depends on tcw_pkg, tcw_ram, tcw_addr_unit and assert_macros.svh.
//
// The console accepts one transaction at a time. After reset it blanks
// the whole cell store before req_ready rises. A put or a newline goes
// from S_PUT to S_DONE; one that scrolls goes through S_SCROLL, which
// blanks the old top row, and S_ROT before S_DONE. A clear blanks the
// whole store in S_CLEAR. An in-range read goes through S_RDADDR and
// S_RDWAIT, while an out-of-range read or an unused mode goes straight
// to S_DONE.
// The sequencer reaches the store through a single shared address adder
// that forms both its write and its read address. A finished result waits
// in an output register, so the next request is taken while it is unclaimed.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [7:0]  color,
  input  logic [10:0] cell_index,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [10:0] cursor,
  output logic [7:0]  read_char,
  output logic [7:0]  read_color,
  output logic        scrolled
);

`include "assert_macros.svh"

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PUT    = 8'b0000_0010,
    S_SCROLL = 8'b0000_0100,
    S_ROT    = 8'b0000_1000,
    S_CLEAR  = 8'b0001_0000,
    S_RDADDR = 8'b0010_0000,
    S_RDWAIT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t          state;
  logic            init_pass;
  logic [AW-1:0]   cur_lin;
  logic [CW-1:0]   cur_col;
  logic [AW-1:0]   top_base;
  logic [AW-1:0]   sweep_cnt;
  logic [7:0]      char_reg;
  logic [7:0]      color_reg;
  logic [10:0]     idx_reg;
  logic [7:0]      res_char;
  logic [7:0]      res_color;
  logic            res_scrolled;

  logic [AW-1:0]   unit_a;
  logic [AW-1:0]   unit_b;
  logic [AW-1:0]   unit_sum;
  logic            ram_we;
  tcw_pkg::cell_t  ram_wdata;
  logic [tcw_pkg::CELL_BITS-1:0] ram_rdata;
  tcw_pkg::cell_t  rd_cell;

  logic [AW+10:0]  idx_ext;
  logic [AW+10:0]  lin_ext;
  logic [AW:0]     pos_next;
  logic [CW-1:0]   col_next;
  logic            is_newline;
  logic            wraps;
  logic            rsp_free;

  assign req_ready  = (state == S_IDLE);
  assign rsp_free   = !rsp_valid || rsp_ready;
  assign idx_ext    = {{AW{1'b0}}, idx_reg};
  assign lin_ext    = {11'b0, cur_lin};
  assign is_newline = (char_reg == tcw_pkg::NEWLINE_CODE);
  assign rd_cell    = tcw_pkg::cell_t'(ram_rdata);

  always_comb begin
    if (is_newline) begin
      pos_next = {1'b0, cur_lin} - (AW+1)'(cur_col) + (AW+1)'(COLUMNS);
      col_next = '0;
    end else begin
      pos_next = {1'b0, cur_lin} + (AW+1)'(1);
      col_next = (cur_col == CW'(COLUMNS - 1)) ? '0 : cur_col + CW'(1);
    end
  end

  assign wraps = (pos_next >= (AW+1)'(CELLS));

  always_comb begin
    unit_a    = top_base;
    unit_b    = cur_lin;
    ram_we    = 1'b0;
    ram_wdata = tcw_pkg::BLANK_CELL;
    case (state)
      S_PUT: begin
        ram_we    = !is_newline;
        ram_wdata = '{color: color_reg, code: char_reg};
      end
      S_SCROLL: begin
        unit_b = sweep_cnt;
        ram_we = 1'b1;
      end
      S_ROT: begin
        unit_b = AW'(COLUMNS);
      end
      S_CLEAR: begin
        unit_a = '0;
        unit_b = sweep_cnt;
        ram_we = 1'b1;
      end
      S_RDADDR: begin
        unit_b = idx_ext[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  tcw_addr_unit #(.CELLS(CELLS)) u_addr (
    .a   (unit_a),
    .b   (unit_b),
    .sum (unit_sum)
  );

  tcw_ram #(.WIDTH(tcw_pkg::CELL_BITS), .DEPTH(CELLS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (unit_sum),
    .wdata (ram_wdata),
    .raddr (unit_sum),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      init_pass <= 1'b1;
      cur_lin   <= '0;
      cur_col   <= '0;
      top_base  <= '0;
      sweep_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            char_reg     <= char_code;
            color_reg    <= color;
            idx_reg      <= cell_index;
            res_char     <= '0;
            res_color    <= '0;
            res_scrolled <= 1'b0;
            sweep_cnt    <= '0;
            case (mode)
              tcw_pkg::MODE_PUT: begin
                state <= S_PUT;
              end
              tcw_pkg::MODE_CLEAR: begin
                cur_lin  <= '0;
                cur_col  <= '0;
                top_base <= '0;
                state    <= S_CLEAR;
              end
              tcw_pkg::MODE_READ: begin
                state <= (32'(cell_index) < CELLS) ? S_RDADDR : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PUT: begin
          cur_col <= col_next;
          if (wraps) begin
            cur_lin      <= AW'(pos_next - (AW+1)'(COLUMNS));
            res_scrolled <= 1'b1;
            state        <= S_SCROLL;
          end else begin
            cur_lin <= pos_next[AW-1:0];
            state   <= S_DONE;
          end
        end
        S_SCROLL: begin
          sweep_cnt <= sweep_cnt + AW'(1);
          if (sweep_cnt == AW'(COLUMNS - 1)) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          top_base <= unit_sum;
          state    <= S_DONE;
        end
        S_CLEAR: begin
          sweep_cnt <= sweep_cnt + AW'(1);
          if (sweep_cnt == AW'(CELLS - 1)) begin
            init_pass <= 1'b0;
            state     <= init_pass ? S_IDLE : S_DONE;
          end
        end
        S_RDADDR: begin
          state <= S_RDWAIT;
        end
        S_RDWAIT: begin
          res_char  <= rd_cell.code;
          res_color <= rd_cell.color;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      cursor     <= lin_ext[10:0];
      read_char  <= res_char;
      read_color <= res_color;
      scrolled   <= res_scrolled;
    end
  end

  `ASSERT_HOLDS(a_cursor_range, clk, rst, {1'b0, cur_lin} < (AW+1)'(CELLS), "cursor past end")
  `ASSERT_HOLDS(a_column_range, clk, rst, cur_col <= CW'(COLUMNS - 1), "column out of range")
  `ASSERT_HOLDS(a_top_range, clk, rst, {1'b0, top_base} < (AW+1)'(CELLS), "top row past end")
  `ASSERT_NEXT(a_busy, clk, rst, req_valid && req_ready, !req_ready, "ready after accept")
  `ASSERT_NEXT(a_scroll, clk, rst, state == S_ROT, res_scrolled && state == S_DONE, "bad scroll")

endmodule

FILE: test/tb_text_console_writer_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer_top: puts, newlines, scrolls, clears and reads.
// Depends on tcw_pkg and the console RTL; keeps its own copy of the screen to predict each result.
module tb_text_console_writer_top;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [10:0] cursor;
    logic [7:0]  rchar;
    logic [7:0]  rcolor;
    logic        scrolled;
  } console_result_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [1:0]  mode;
  logic [7:0]  char_code;
  logic [7:0]  color;
  logic [10:0] cell_index;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [10:0] cursor;
  logic [7:0]  read_char;
  logic [7:0]  read_color;
  logic        scrolled;

  tcw_pkg::cell_t  screen [CELLS];
  int unsigned     cur_pos;
  int unsigned     top_row_q;
  console_result_t expected_q[$];

  int          errors = 0;
  int unsigned cycle_count = 0;
  int unsigned n_put = 0, n_newline = 0, n_read = 0, n_read_oob = 0;
  int unsigned n_clear = 0, n_unused = 0, n_scroll = 0, n_checked = 0;
  bit          sender_gaps = 1'b1;
  bit          hold_rsp = 1'b0;

  text_console_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .mode(mode),
    .char_code(char_code),
    .color(color),
    .cell_index(cell_index),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .cursor(cursor),
    .read_char(read_char),
    .read_color(read_color),
    .scrolled(scrolled)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles with %0d results outstanding",
             $time, cycle_count, expected_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [10:0] rand_index();
    return 11'($urandom_range(0, 2047));
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    c = rand_byte();
    return (c == tcw_pkg::NEWLINE_CODE) ? 8'h2A : c;
  endfunction

  function automatic int unsigned screen_slot(int unsigned logical);
    return ((top_row_q + logical / COLUMNS) % ROWS) * COLUMNS + logical % COLUMNS;
  endfunction

  function automatic void blank_screen();
    foreach (screen[i]) screen[i] = tcw_pkg::BLANK_CELL;
    cur_pos = 0;
    top_row_q = 0;
  endfunction

  function automatic void predict_console(tcw_pkg::mode_t m, logic [7:0] ch, logic [7:0] attr,
                                          logic [10:0] idx);
    console_result_t res;
    int unsigned pos;
    int unsigned slot;
    res = '0;
    case (m)
      tcw_pkg::MODE_PUT: begin
        pos = cur_pos;
        if (ch == tcw_pkg::NEWLINE_CODE) begin
          pos = (pos / COLUMNS + 1) * COLUMNS;
          n_newline++;
        end else begin
          slot = screen_slot(pos);
          screen[slot].code = ch;
          screen[slot].color = attr;
          pos++;
          n_put++;
        end
        if (pos >= CELLS) begin
          for (int c = 0; c < COLUMNS; c++) begin
            screen[top_row_q * COLUMNS + c] = tcw_pkg::BLANK_CELL;
          end
          top_row_q = (top_row_q + 1) % ROWS;
          pos -= COLUMNS;
          res.scrolled = 1'b1;
          n_scroll++;
        end
        cur_pos = pos;
      end
      tcw_pkg::MODE_CLEAR: begin
        blank_screen();
        n_clear++;
      end
      tcw_pkg::MODE_READ: begin
        n_read++;
        if (32'(idx) < CELLS) begin
          slot = screen_slot(32'(idx));
          res.rchar = screen[slot].code;
          res.rcolor = screen[slot].color;
        end else begin
          n_read_oob++;
        end
      end
      default: n_unused++;
    endcase
    res.cursor = cur_pos[10:0];
    expected_q.push_back(res);
  endfunction

  task automatic send_item(tcw_pkg::mode_t m, logic [7:0] ch, logic [7:0] attr,
                           logic [10:0] idx);
    int unsigned g;
    req_valid <= 1'b1;
    mode <= m;
    char_code <= ch;
    color <= attr;
    cell_index <= idx;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_console(m, ch, attr, idx);
    g = sender_gaps ? pick_gap() : 0;
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_read(logic [10:0] idx);
    send_item(tcw_pkg::MODE_READ, rand_byte(), rand_byte(), idx);
  endtask

  function automatic logic [10:0] near_cursor();
    int unsigned d;
    d = $urandom_range(0, 160);
    return 11'((cur_pos >= d) ? cur_pos - d : d);
  endfunction

  initial begin : rsp_side
    int unsigned gap_left;
    int unsigned style_left;
    bit steady;
    gap_left = 0;
    style_left = 0;
    steady = 1'b0;
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end
      if (style_left == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        style_left = $urandom_range(30, 150);
      end
      style_left--;
      if (steady) begin
        rsp_ready <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        rsp_ready <= 1'b0;
      end else begin
        gap_left = pick_gap();
        if (gap_left == 0) begin
          rsp_ready <= 1'b1;
        end else begin
          rsp_ready <= 1'b0;
          gap_left--;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    console_result_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, cursor %0d char %0d color %0d scrolled %0d",
                 $time, cursor, read_char, read_color, scrolled);
        errors++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (cursor !== want.cursor) begin
          $display("%0t: cursor expected %0d actual %0d", $time, want.cursor, cursor);
          errors++;
        end
        if (read_char !== want.rchar) begin
          $display("%0t: read_char expected %0d actual %0d", $time, want.rchar, read_char);
          errors++;
        end
        if (read_color !== want.rcolor) begin
          $display("%0t: read_color expected %0d actual %0d", $time, want.rcolor, read_color);
          errors++;
        end
        if (scrolled !== want.scrolled) begin
          $display("%0t: scrolled expected %0d actual %0d", $time, want.scrolled, scrolled);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_read(11'd0);
    send_item(tcw_pkg::MODE_PUT, 8'h00, 8'h00, 11'd0);
    send_item(tcw_pkg::MODE_PUT, 8'hFF, 8'hFF, 11'h7FF);
    send_item(tcw_pkg::MODE_PUT, 8'h41, 8'h5A, 11'd5);
    send_item(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 8'hC3, 11'd9);
    send_item(tcw_pkg::MODE_PUT, 8'hAA, 8'h55, 11'd0);
    send_read(11'd0);
    send_read(11'd1);
    send_read(11'd2);
    send_read(11'd3);
    send_read(11'd80);
    send_read(11'd1999);
    send_read(11'd2000);
    send_read(11'h7FF);
    send_item(tcw_pkg::MODE_NONE, 8'hFF, 8'hFF, 11'h7FF);
    send_item(tcw_pkg::MODE_NONE, 8'h00, 8'h00, 11'd0);
    send_item(tcw_pkg::MODE_CLEAR, 8'h41, 8'h12, 11'd3);
    send_read(11'd0);
    send_read(11'd80);
    send_item(tcw_pkg::MODE_PUT, 8'h7E, 8'h81, 11'd0);
    send_read(11'd0);
  endtask

  task automatic test_scroll();
    int k;
    send_item(tcw_pkg::MODE_CLEAR, 8'h00, 8'h00, 11'd0);
    for (int line = 0; line < 30; line++) begin
      k = $urandom_range(0, 6);
      repeat (k) send_item(tcw_pkg::MODE_PUT, rand_char(), rand_byte(), 11'd0);
      send_item(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, rand_byte(), rand_index());
      if (line % 5 == 4) send_read(near_cursor());
    end
    repeat (170) send_item(tcw_pkg::MODE_PUT, rand_char(), rand_byte(), 11'd0);
    repeat (30) send_read(($urandom_range(0, 1) == 0) ? near_cursor() :
                          11'($urandom_range(0, CELLS - 1)));
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_rsp = 1'b1;
    repeat (12) begin
      if ($urandom_range(0, 1) == 0) send_item(tcw_pkg::MODE_PUT, rand_char(), rand_byte(), 11'd0);
      else send_read(near_cursor());
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_random();
    int unsigned r;
    int unsigned s;
    logic [10:0] idx;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) sender_gaps = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 999);
      if (r < 4) begin
        send_item(tcw_pkg::MODE_CLEAR, rand_byte(), rand_byte(), rand_index());
      end else if (r < 30) begin
        send_item(tcw_pkg::MODE_NONE, rand_byte(), rand_byte(), rand_index());
      end else if (r < 160) begin
        send_item(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, rand_byte(), rand_index());
      end else if (r < 430) begin
        s = $urandom_range(0, 9);
        if (s < 4) idx = near_cursor();
        else if (s < 9) idx = 11'($urandom_range(0, CELLS - 1));
        else idx = 11'($urandom_range(CELLS, 2047));
        send_read(idx);
      end else begin
        send_item(tcw_pkg::MODE_PUT, rand_byte(), rand_byte(), rand_index());
      end
    end
    sender_gaps = 1'b1;
  endtask

  initial begin : main
    rst = 1'b1;
    req_valid = 1'b0;
    mode = tcw_pkg::MODE_NONE;
    char_code = 8'h00;
    color = 8'h00;
    cell_index = 11'd0;
    blank_screen();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_scroll();
    test_backpressure();
    test_random();

    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d characters, %0d newlines, %0d scrolls, %0d clears.",
             n_checked, n_put, n_newline, n_scroll, n_clear);
    $display("Reads: %0d (%0d past the screen), unused-mode transactions: %0d.",
             n_read, n_read_oob, n_unused);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
